// ----- rtl/jpeg_baseline_header_parser_macros.svh -----
// Assertion macros shared by the checker of the JPEG header parser.
`ifndef JPEG_BASELINE_HEADER_PARSER_MACROS_SVH
`define JPEG_BASELINE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define JBHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define JBHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/jbhp_pkg.sv -----
// Types, codes and constants of the JPEG baseline header parser.
package jbhp_pkg;

  localparam logic [3:0] PH_SOI0      = 4'd0;
  localparam logic [3:0] PH_SOI1      = 4'd1;
  localparam logic [3:0] PH_MARK      = 4'd2;
  localparam logic [3:0] PH_LENH      = 4'd3;
  localparam logic [3:0] PH_LENL      = 4'd4;
  localparam logic [3:0] PH_SKIP      = 4'd5;
  localparam logic [3:0] PH_DQT       = 4'd6;
  localparam logic [3:0] PH_DHT_HEAD  = 4'd7;
  localparam logic [3:0] PH_DHT_COUNT = 4'd8;
  localparam logic [3:0] PH_DHT_SYM   = 4'd9;
  localparam logic [3:0] PH_SOF       = 4'd10;
  localparam logic [3:0] PH_DRI       = 4'd11;
  localparam logic [3:0] PH_SOS       = 4'd12;
  localparam logic [3:0] PH_SCAN      = 4'd13;

  localparam logic [3:0] KIND_QUANT     = 4'd0;
  localparam logic [3:0] KIND_HUFF_CNT  = 4'd1;
  localparam logic [3:0] KIND_HUFF_SYM  = 4'd2;
  localparam logic [3:0] KIND_HEIGHT    = 4'd3;
  localparam logic [3:0] KIND_WIDTH     = 4'd4;
  localparam logic [3:0] KIND_PRECISION = 4'd5;
  localparam logic [3:0] KIND_RESTART   = 4'd6;
  localparam logic [3:0] KIND_SAMPLING  = 4'd7;
  localparam logic [3:0] KIND_COMP_QT   = 4'd8;
  localparam logic [3:0] KIND_COMP_HUFF = 4'd9;
  localparam logic [3:0] KIND_HDR_DONE  = 4'd10;
  localparam logic [3:0] KIND_SCAN      = 4'd11;
  localparam logic [3:0] KIND_ERROR     = 4'd12;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_SOI    = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED = 3'd2;
  localparam logic [2:0] ERR_PRECISION = 3'd3;
  localparam logic [2:0] ERR_COMPONENT = 3'd4;
  localparam logic [2:0] ERR_CODING    = 3'd5;
  localparam logic [2:0] ERR_CORRUPT   = 3'd6;

  localparam logic [7:0] MK_FILL = 8'hff;
  localparam logic [7:0] MK_SOI  = 8'hd8;
  localparam logic [7:0] MK_EOI  = 8'hd9;
  localparam logic [7:0] MK_SOS  = 8'hda;
  localparam logic [7:0] MK_DQT  = 8'hdb;
  localparam logic [7:0] MK_DHT  = 8'hc4;
  localparam logic [7:0] MK_SOF0 = 8'hc0;
  localparam logic [7:0] MK_SOF1 = 8'hc1;
  localparam logic [7:0] MK_JPG  = 8'hc8;
  localparam logic [7:0] MK_SOFF = 8'hcf;
  localparam logic [7:0] MK_DRI  = 8'hdd;
  localparam logic [7:0] MK_DAC  = 8'hcc;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  segment_marker;
    logic [15:0] segment_remaining;
    logic [7:0]  length_high;
    logic [11:0] chunk_position;
    logic [2:0]  table_slot;
    logic [11:0] symbols_remaining;
    logic [7:0]  component_count;
    logic [7:0]  component_done;
    logic [1:0]  current_component;
    logic        error_seen;
  } state_t;

  typedef struct packed {
    logic        have;
    logic [3:0]  kind;
    logic [2:0]  slot;
    logic [7:0]  index;
    logic [15:0] value;
    logic [2:0]  error_code;
  } result_t;

  localparam state_t ST_RESET = '{phase: PH_SOI0, default: '0};

endpackage

// ----- rtl/jpeg_baseline_header_parser.sv -----
// Top level of the baseline JPEG header parser: state and result registers.
//
//  channel  | dir | tdata                        | tuser    | tlast
//  s_*      | in  | [7:0] data_byte              | -        | last_byte
//  m_*      | out | slot,index,value,error_code  | [3:0] kind | -
//
// One byte per cycle while the m side is not stalled; a byte's result is registered
// behind it (input register, then result register).
// The decode step updates the parser state in the cycle the byte moves on.
// rst clears both stages and returns the parser to expecting SOI.
// A stalled m side holds the result; one more byte waits in the input register.
module jpeg_baseline_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] slot, [10:3] index, [26:11] value, [29:27] error_code
  output logic [3:0]  m_tuser    // [3:0] kind
);

  logic               advance;
  logic               in_valid;
  jbhp_pkg::in_item_t in_item;
  jbhp_pkg::state_t   st;
  jbhp_pkg::state_t   st_next;
  jbhp_pkg::result_t  res;

  assign advance = !m_tvalid || m_tready;

  jbhp_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .in_valid (in_valid),
    .in_item  (in_item)
  );

  jbhp_step u_step (
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= jbhp_pkg::ST_RESET;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && res.have;
      if (in_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && res.have) begin
      m_tdata <= {2'b00, res.error_code, res.value, res.index, res.slot};
      m_tuser <= res.kind;
    end
  end

endmodule

// ----- rtl/jbhp_in_stage.sv -----
// Input register of the header parser: holds one byte until the decode step takes it.
module jbhp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte
  input  logic               s_tlast,
  input  logic               advance,
  output logic               in_valid,
  output jbhp_pkg::in_item_t in_item
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.data_byte <= s_tdata;
      in_item.last_byte <= s_tlast;
    end
  end

endmodule

// ----- rtl/jbhp_step.sv -----
// Per-byte decode: next parser state and the result item that one byte produces.
module jbhp_step (
  input  jbhp_pkg::state_t   st,
  input  jbhp_pkg::in_item_t item,
  output jbhp_pkg::state_t   st_next,
  output jbhp_pkg::result_t  res
);

  function automatic jbhp_pkg::result_t mk_res(logic [3:0] kind, logic [2:0] slot,
                                               logic [7:0] index, logic [15:0] value,
                                               logic [2:0] code);
    jbhp_pkg::result_t r;
    r.have       = 1'b1;
    r.kind       = kind;
    r.slot       = slot;
    r.index      = index;
    r.value      = value;
    r.error_code = code;
    return r;
  endfunction

  jbhp_pkg::state_t  n;
  jbhp_pkg::result_t r;
  logic [7:0]  b;
  logic [11:0] p;
  logic        final_b;
  logic        dead;
  logic        was_scan;
  logic [15:0] word;
  logic [15:0] rem;
  logic [11:0] sym_sum;
  logic [11:0] sym_left;
  logic [7:0]  comp_id;
  logic        unsupported;

  always_comb begin
    n        = st;
    r        = '0;
    b        = item.data_byte;
    p        = st.chunk_position;
    final_b  = (st.segment_remaining == 16'd1);
    dead     = st.error_seen;
    was_scan = (st.phase == jbhp_pkg::PH_SCAN);
    word     = {st.length_high, b};
    rem      = word - 16'd2;
    sym_sum  = st.symbols_remaining + {4'd0, b};
    sym_left = st.symbols_remaining - 12'd1;
    comp_id  = b - 8'd1;
    unsupported = (b == jbhp_pkg::MK_DAC) ||
                  ((b >= jbhp_pkg::MK_SOF1) && (b <= jbhp_pkg::MK_SOFF) &&
                   (b != jbhp_pkg::MK_DHT) && (b != jbhp_pkg::MK_JPG));

    if (!dead) begin
      case (st.phase)
        jbhp_pkg::PH_SOI0: begin
          if (b != jbhp_pkg::MK_FILL) begin
            r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0, jbhp_pkg::ERR_NO_SOI);
            n.error_seen = 1'b1;
          end else begin
            n.phase = jbhp_pkg::PH_SOI1;
          end
        end
        jbhp_pkg::PH_SOI1: begin
          if (b != jbhp_pkg::MK_SOI) begin
            r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0, jbhp_pkg::ERR_NO_SOI);
            n.error_seen = 1'b1;
          end else begin
            n.phase = jbhp_pkg::PH_MARK;
          end
        end
        jbhp_pkg::PH_MARK: begin
          if (b != jbhp_pkg::MK_FILL) begin
            n.segment_marker = b;
            if (unsupported) begin
              r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0, jbhp_pkg::ERR_CODING);
              n.error_seen = 1'b1;
            end else if ((b == jbhp_pkg::MK_SOI) || (b == jbhp_pkg::MK_EOI)) begin
              r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0, jbhp_pkg::ERR_CORRUPT);
              n.error_seen = 1'b1;
            end else begin
              n.phase = jbhp_pkg::PH_LENH;
            end
          end
        end
        jbhp_pkg::PH_LENH: begin
          n.length_high = b;
          n.phase       = jbhp_pkg::PH_LENL;
        end
        jbhp_pkg::PH_LENL: begin
          if (word < 16'd2) begin
            r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0, jbhp_pkg::ERR_CORRUPT);
            n.error_seen = 1'b1;
          end else begin
            n.segment_remaining = rem;
            n.chunk_position    = 12'd0;
            case (st.segment_marker)
              jbhp_pkg::MK_DQT:  n.phase = jbhp_pkg::PH_DQT;
              jbhp_pkg::MK_DHT:  n.phase = jbhp_pkg::PH_DHT_HEAD;
              jbhp_pkg::MK_SOF0: n.phase = jbhp_pkg::PH_SOF;
              jbhp_pkg::MK_DRI:  n.phase = jbhp_pkg::PH_DRI;
              jbhp_pkg::MK_SOS:  n.phase = jbhp_pkg::PH_SOS;
              default:           n.phase = jbhp_pkg::PH_SKIP;
            endcase
            if (rem == 16'd0) begin
              if (st.segment_marker == jbhp_pkg::MK_SOS) begin
                r = mk_res(jbhp_pkg::KIND_HDR_DONE, 3'd0, 8'd0, 16'd0, jbhp_pkg::ERR_NONE);
                n.phase = jbhp_pkg::PH_SCAN;
              end else begin
                n.phase = jbhp_pkg::PH_MARK;
              end
            end
          end
        end
        jbhp_pkg::PH_SCAN: begin
          r = mk_res(jbhp_pkg::KIND_SCAN, 3'd0, 8'd0, {8'd0, b}, jbhp_pkg::ERR_NONE);
        end
        jbhp_pkg::PH_SKIP, jbhp_pkg::PH_DQT, jbhp_pkg::PH_DHT_HEAD, jbhp_pkg::PH_DHT_COUNT,
        jbhp_pkg::PH_DHT_SYM, jbhp_pkg::PH_SOF, jbhp_pkg::PH_DRI, jbhp_pkg::PH_SOS: begin
          n.segment_remaining = st.segment_remaining - 16'd1;
          case (st.phase)
            jbhp_pkg::PH_DQT: begin
              if (p == 12'd0) begin
                if (b[7:4] != 4'd0) begin
                  r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0,
                             jbhp_pkg::ERR_PRECISION);
                  n.error_seen = 1'b1;
                end else begin
                  n.table_slot     = {1'b0, b[1:0]};
                  n.chunk_position = 12'd1;
                end
              end else begin
                r = mk_res(jbhp_pkg::KIND_QUANT, st.table_slot, p[7:0] - 8'd1,
                           {8'd0, b}, jbhp_pkg::ERR_NONE);
                n.chunk_position = (p >= 12'd64) ? 12'd0 : p + 12'd1;
              end
            end
            jbhp_pkg::PH_DHT_HEAD: begin
              n.table_slot        = {b[1:0], b[4]};
              n.chunk_position    = 12'd0;
              n.symbols_remaining = 12'd0;
              n.phase             = jbhp_pkg::PH_DHT_COUNT;
            end
            jbhp_pkg::PH_DHT_COUNT: begin
              r = mk_res(jbhp_pkg::KIND_HUFF_CNT, st.table_slot, p[7:0], {8'd0, b},
                         jbhp_pkg::ERR_NONE);
              n.symbols_remaining = sym_sum;
              if (p >= 12'd15) begin
                n.chunk_position = 12'd0;
                n.phase = (sym_sum != 12'd0) ? jbhp_pkg::PH_DHT_SYM : jbhp_pkg::PH_DHT_HEAD;
              end else begin
                n.chunk_position = p + 12'd1;
              end
            end
            jbhp_pkg::PH_DHT_SYM: begin
              if (p <= 12'd255) begin
                r = mk_res(jbhp_pkg::KIND_HUFF_SYM, st.table_slot, p[7:0], {8'd0, b},
                           jbhp_pkg::ERR_NONE);
              end
              n.chunk_position    = p + 12'd1;
              n.symbols_remaining = sym_left;
              if (sym_left == 12'd0) begin
                n.phase = jbhp_pkg::PH_DHT_HEAD;
              end
            end
            jbhp_pkg::PH_SOF: begin
              if (p == 12'd0) begin
                r = mk_res(jbhp_pkg::KIND_PRECISION, 3'd0, 8'd0, {8'd0, b},
                           jbhp_pkg::ERR_NONE);
              end else if ((p == 12'd1) || (p == 12'd3)) begin
                n.length_high = b;
              end else if (p == 12'd2) begin
                r = mk_res(jbhp_pkg::KIND_HEIGHT, 3'd0, 8'd0, word, jbhp_pkg::ERR_NONE);
              end else if (p == 12'd4) begin
                r = mk_res(jbhp_pkg::KIND_WIDTH, 3'd0, 8'd0, word, jbhp_pkg::ERR_NONE);
              end else if (p == 12'd5) begin
                n.component_count = b;
                n.component_done  = 8'd0;
              end else if (st.component_done < st.component_count) begin
                if (p == 12'd6) begin
                  if (comp_id > 8'd2) begin
                    r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0,
                               jbhp_pkg::ERR_COMPONENT);
                    n.error_seen = 1'b1;
                  end else begin
                    n.current_component = comp_id[1:0];
                  end
                end else if (p == 12'd7) begin
                  r = mk_res(jbhp_pkg::KIND_SAMPLING, {1'b0, st.current_component}, 8'd0,
                             {8'd0, b}, jbhp_pkg::ERR_NONE);
                end else begin
                  r = mk_res(jbhp_pkg::KIND_COMP_QT, {1'b0, st.current_component}, 8'd0,
                             {8'd0, b}, jbhp_pkg::ERR_NONE);
                  n.component_done = st.component_done + 8'd1;
                end
              end
              n.chunk_position = (p >= 12'd8) ? 12'd6 : p + 12'd1;
            end
            jbhp_pkg::PH_DRI: begin
              if (p == 12'd0) begin
                n.length_high = b;
              end else if (p == 12'd1) begin
                r = mk_res(jbhp_pkg::KIND_RESTART, 3'd0, 8'd0, word, jbhp_pkg::ERR_NONE);
              end
              if (p < 12'd2) begin
                n.chunk_position = p + 12'd1;
              end
            end
            jbhp_pkg::PH_SOS: begin
              if (p == 12'd0) begin
                n.component_count = b;
                n.component_done  = 8'd0;
              end else if (st.component_done < st.component_count) begin
                if (p == 12'd1) begin
                  if (comp_id > 8'd2) begin
                    r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0,
                               jbhp_pkg::ERR_COMPONENT);
                    n.error_seen = 1'b1;
                  end else begin
                    n.current_component = comp_id[1:0];
                  end
                end else begin
                  r = mk_res(jbhp_pkg::KIND_COMP_HUFF, {1'b0, st.current_component}, 8'd0,
                             {8'd0, b}, jbhp_pkg::ERR_NONE);
                  n.component_done = st.component_done + 8'd1;
                end
              end
              n.chunk_position = (p >= 12'd2) ? 12'd1 : p + 12'd1;
            end
            default: begin
            end
          endcase
          // end of segment; an error raised on this byte wins
          if (final_b && !n.error_seen) begin
            if (st.segment_marker == jbhp_pkg::MK_SOS) begin
              r = mk_res(jbhp_pkg::KIND_HDR_DONE, 3'd0, 8'd0, 16'd0, jbhp_pkg::ERR_NONE);
              n.phase = jbhp_pkg::PH_SCAN;
            end else begin
              n.phase = jbhp_pkg::PH_MARK;
            end
          end
        end
        default: begin
          n.phase = jbhp_pkg::PH_MARK;
        end
      endcase
    end

    if (item.last_byte) begin
      if (!dead && !was_scan && !(r.have && (r.kind == jbhp_pkg::KIND_ERROR))) begin
        r = mk_res(jbhp_pkg::KIND_ERROR, 3'd0, 8'd0, 16'd0, jbhp_pkg::ERR_TRUNCATED);
      end
      n = jbhp_pkg::ST_RESET;
    end

    st_next = n;
    res     = r;
  end

endmodule

// ----- rtl/jbhp_checker.sv -----
// Port-level checks on the result stream of the header parser, with its bind.
`include "jpeg_baseline_header_parser_macros.svh"

module jbhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [3:0]  m_tuser
);

  `JBHP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")
  `JBHP_ASSERT_NOW(a_kind, m_tvalid, m_tuser <= jbhp_pkg::KIND_ERROR, "kind out of range")
  `JBHP_ASSERT_NOW(a_code, m_tvalid && (m_tuser != jbhp_pkg::KIND_ERROR), m_tdata[29:27] == jbhp_pkg::ERR_NONE, "error code on non-error result")
  `JBHP_ASSERT_NOW(a_bare, m_tvalid && ((m_tuser == jbhp_pkg::KIND_ERROR) || (m_tuser == jbhp_pkg::KIND_HDR_DONE)), m_tdata[26:0] == 27'd0, "payload on bare result")

endmodule

bind jpeg_baseline_header_parser jbhp_checker u_checker (.*);
